@@ rtl/tcfla_pkg.sv @@
// Shared constants and derived widths for the two-class free-list allocator.
package tcfla_pkg;

    // Block and heap geometry
    localparam int SMALL_BYTES = 32;
    localparam int LARGE_BYTES = 64;
    localparam int HEAP_BYTES  = 65536;

    // Item field widths
    localparam int ADDR_W = 16;
    localparam int REQ_W  = 7;

    // Derived sizes
    localparam int HEAP_AW     = $clog2(HEAP_BYTES);
    localparam int SMALL_SHIFT = $clog2(SMALL_BYTES);
    localparam int LARGE_SHIFT = $clog2(LARGE_BYTES);
    localparam int SMALL_DEPTH = HEAP_BYTES / SMALL_BYTES;
    localparam int LARGE_DEPTH = HEAP_BYTES / LARGE_BYTES;
    localparam int SMALL_IW    = HEAP_AW - SMALL_SHIFT;   // small block index
    localparam int LARGE_IW    = HEAP_AW - LARGE_SHIFT;   // large block index
    localparam int SMALL_CW    = SMALL_IW + 1;            // small stack count
    localparam int LARGE_CW    = LARGE_IW + 1;            // large stack count
    localparam int TOP_W       = HEAP_AW + 1;             // heap bump pointer
    localparam int SUM_W       = HEAP_AW + 2;             // bump pointer plus block

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

endpackage

@@ rtl/tcfla_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tcfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/two_class_free_list_allocator_top.sv @@
// Top level of the two-class free-list allocator: request decode, stacks and bump pointer.

// Each accepted item (allocate or free) is finished in the cycle it is accepted
// and its result appears in the output register on the next cycle; one item is
// taken every cycle while the result side keeps up. Each free stack keeps its
// top entry in a register and the entry just below it either in a register
// (after a push) or in the registered read port of its stack RAM (after a pop,
// which fetches the next lower entry), so a pop never waits for memory. Stack
// RAMs need no initialization after reset; the block is ready in the first
// cycle after reset is released.
module two_class_free_list_allocator_top
    import tcfla_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0] i_freed_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_block_address,
    output logic              o_status
);

    // Control state
    logic                r_out_valid, n_out_valid;
    logic [SMALL_CW-1:0] r_s_cnt, n_s_cnt;
    logic [LARGE_CW-1:0] r_l_cnt, n_l_cnt;
    logic [TOP_W-1:0]    r_heap_top, n_heap_top;
    logic                r_s_sel, n_s_sel;
    logic                r_l_sel, n_l_sel;

    // Payload state
    logic [SMALL_IW-1:0] r_s_top, n_s_top;
    logic [SMALL_IW-1:0] r_s_below, n_s_below;
    logic [LARGE_IW-1:0] r_l_top, n_l_top;
    logic [LARGE_IW-1:0] r_l_below, n_l_below;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic                r_status, n_status;

    // RAM ports
    logic                s_we, s_re, l_we, l_re;
    logic [SMALL_IW-1:0] s_waddr, s_raddr, s_wdata, s_rdata;
    logic [LARGE_IW-1:0] l_waddr, l_raddr, l_wdata, l_rdata;

    // Decode helpers
    logic                accept;
    logic                small_req;
    logic                pad;
    logic [SUM_W-1:0]    small_end, large_end;
    logic [SMALL_IW-1:0] s_below;
    logic [LARGE_IW-1:0] l_below;
    logic                s_push, l_push;
    logic [SMALL_IW-1:0] s_push_val;

    assign o_ready   = !r_out_valid || i_ready;
    assign accept    = i_valid && o_ready;
    assign small_req = (i_request_bytes <= REQ_W'(SMALL_BYTES));
    assign pad       = (r_heap_top[LARGE_SHIFT-1:0] != '0);
    assign small_end = SUM_W'(r_heap_top) + SUM_W'(SMALL_BYTES);
    assign large_end = SUM_W'(r_heap_top) + SUM_W'(LARGE_BYTES)
                     + (pad ? SUM_W'(SMALL_BYTES) : SUM_W'(0));
    assign s_below   = r_s_sel ? r_s_below : s_rdata;
    assign l_below   = r_l_sel ? r_l_below : l_rdata;

    // Request decode and state update
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_s_cnt     = r_s_cnt;
        n_l_cnt     = r_l_cnt;
        n_heap_top  = r_heap_top;
        n_s_sel     = r_s_sel;
        n_l_sel     = r_l_sel;
        n_s_top     = r_s_top;
        n_s_below   = r_s_below;
        n_l_top     = r_l_top;
        n_l_below   = r_l_below;
        n_addr      = r_addr;
        n_status    = r_status;
        s_push      = 1'b0;
        l_push      = 1'b0;
        s_push_val  = i_freed_address[HEAP_AW-1:SMALL_SHIFT];
        s_re        = 1'b0;
        l_re        = 1'b0;
        s_raddr     = SMALL_IW'(r_s_cnt - SMALL_CW'(3));
        l_raddr     = LARGE_IW'(r_l_cnt - LARGE_CW'(3));

        if (accept) begin
            n_out_valid = 1'b1;
            n_addr      = '0;
            n_status    = STATUS_OK;
            if (i_mode == MODE_FREE) begin
                // free: tag bit picks the stack
                if (i_freed_address[0]) begin
                    s_push = 1'b1;
                end else begin
                    l_push = 1'b1;
                end
            end else if (small_req) begin
                if (r_s_cnt != '0) begin
                    // pop small stack
                    n_addr  = (ADDR_W'(r_s_top) << SMALL_SHIFT) | ADDR_W'(1);
                    n_s_cnt = r_s_cnt - SMALL_CW'(1);
                    n_s_top = s_below;
                    n_s_sel = 1'b0;
                    s_re    = 1'b1;
                end else if (small_end <= SUM_W'(HEAP_BYTES)) begin
                    // bump small block
                    n_addr     = ADDR_W'(r_heap_top) | ADDR_W'(1);
                    n_heap_top = TOP_W'(small_end);
                end else begin
                    n_status = STATUS_EXHAUSTED;
                end
            end else begin
                if (r_l_cnt != '0) begin
                    // pop large stack
                    n_addr  = ADDR_W'(r_l_top) << LARGE_SHIFT;
                    n_l_cnt = r_l_cnt - LARGE_CW'(1);
                    n_l_top = l_below;
                    n_l_sel = 1'b0;
                    l_re    = 1'b1;
                end else if (large_end <= SUM_W'(HEAP_BYTES)) begin
                    // bump large block, padding to alignment if needed
                    s_push     = pad;
                    s_push_val = r_heap_top[HEAP_AW-1:SMALL_SHIFT];
                    n_addr     = ADDR_W'(r_heap_top)
                               + (pad ? ADDR_W'(SMALL_BYTES) : ADDR_W'(0));
                    n_heap_top = TOP_W'(large_end);
                end else begin
                    n_status = STATUS_EXHAUSTED;
                end
            end
        end

        // Small push: old top moves below, unless the stack is full
        if (s_push && (r_s_cnt != SMALL_CW'(SMALL_DEPTH))) begin
            n_s_cnt   = r_s_cnt + SMALL_CW'(1);
            n_s_top   = s_push_val;
            n_s_below = r_s_top;
            n_s_sel   = 1'b1;
        end

        // Large push
        if (l_push && (r_l_cnt != LARGE_CW'(LARGE_DEPTH))) begin
            n_l_cnt   = r_l_cnt + LARGE_CW'(1);
            n_l_top   = i_freed_address[HEAP_AW-1:LARGE_SHIFT];
            n_l_below = r_l_top;
            n_l_sel   = 1'b1;
        end
    end

    // Spill the old top into the RAM on a push to a stack that is neither empty nor full
    assign s_we    = s_push && (r_s_cnt != '0) && (r_s_cnt != SMALL_CW'(SMALL_DEPTH));
    assign s_waddr = SMALL_IW'(r_s_cnt - SMALL_CW'(1));
    assign s_wdata = r_s_top;
    assign l_we    = l_push && (r_l_cnt != '0) && (r_l_cnt != LARGE_CW'(LARGE_DEPTH));
    assign l_waddr = LARGE_IW'(r_l_cnt - LARGE_CW'(1));
    assign l_wdata = r_l_top;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_s_cnt     <= '0;
            r_l_cnt     <= '0;
            r_heap_top  <= '0;
            r_s_sel     <= 1'b1;
            r_l_sel     <= 1'b1;
        end else begin
            r_out_valid <= n_out_valid;
            r_s_cnt     <= n_s_cnt;
            r_l_cnt     <= n_l_cnt;
            r_heap_top  <= n_heap_top;
            r_s_sel     <= n_s_sel;
            r_l_sel     <= n_l_sel;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s_top   <= n_s_top;
        r_s_below <= n_s_below;
        r_l_top   <= n_l_top;
        r_l_below <= n_l_below;
        r_addr    <= n_addr;
        r_status  <= n_status;
    end

    // Stack storage below the cached entries
    tcfla_ram #(
        .WIDTH (SMALL_IW),
        .DEPTH (SMALL_DEPTH)
    ) u_small_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    tcfla_ram #(
        .WIDTH (LARGE_IW),
        .DEPTH (LARGE_DEPTH)
    ) u_large_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign o_valid         = r_out_valid;
    assign o_block_address = r_addr;
    assign o_status        = r_status;

endmodule
